// File: sv/rrf_pkg.sv
// Shared types, constants and functions of the RTU request frame receiver.
`timescale 1ns / 1ps
package rrf_pkg;

  localparam logic [7:0]  FC_READ        = 8'h04;
  localparam logic [7:0]  FC_WRITE       = 8'h10;
  localparam logic [15:0] MAX_WC_RESET   = 16'd100;
  localparam logic [7:0]  OWN_ID_RESET   = 8'h00;
  localparam logic [15:0] CRC_INIT       = 16'hFFFF;
  localparam logic [15:0] CRC_POLY       = 16'hA001;

  // Configuration register indexes.
  localparam logic REG_OWN_SLAVE_ID   = 1'b0;
  localparam logic REG_MAX_WORD_COUNT = 1'b1;

  localparam int ADDR_TABLE_SIZE    = 28;
  localparam int ADDR_TABLE_ENTRIES = 28;
  localparam int ADDR_TABLE_USED    =
    (ADDR_TABLE_ENTRIES < ADDR_TABLE_SIZE) ? ADDR_TABLE_ENTRIES : ADDR_TABLE_SIZE;

  localparam logic [15:0] KNOWN_ADDR [ADDR_TABLE_SIZE] = '{
    16'h1100, 16'h1200, 16'h2100, 16'h2200, 16'h2300, 16'h2400, 16'h2500, 16'h2600,
    16'h2700, 16'h2800, 16'h2900, 16'h3000, 16'h3100, 16'h3200, 16'h4100, 16'h4200,
    16'h4300, 16'h5100, 16'h6100, 16'h7100, 16'h7200, 16'h7300, 16'h7400, 16'h7500,
    16'h7600, 16'h7700, 16'h7900, 16'h8000
  };

  // Event kinds.
  localparam logic [1:0] EV_DATA      = 2'd0;
  localparam logic [1:0] EV_READ_OK   = 2'd1;
  localparam logic [1:0] EV_WRITE_OK  = 2'd2;
  localparam logic [1:0] EV_REJECT    = 2'd3;

  // Reject causes.
  localparam logic [2:0] RC_NONE      = 3'd0;
  localparam logic [2:0] RC_OTHER_ID  = 3'd0;
  localparam logic [2:0] RC_BAD_FUNC  = 3'd1;
  localparam logic [2:0] RC_BAD_ADDR  = 3'd2;
  localparam logic [2:0] RC_COUNT     = 3'd3;
  localparam logic [2:0] RC_CRC       = 3'd4;

  typedef struct packed {
    logic [1:0]  event_kind;
    logic [7:0]  data_byte;
    logic [7:0]  data_index;
    logic [7:0]  function_code;
    logic [15:0] register_address;
    logic [15:0] word_count;
    logic [7:0]  byte_count;
    logic [2:0]  reject_cause;
  } rrf_event_t;

  typedef struct packed {
    logic full;
    logic empty;
  } rrf_q_status_t;

  // Modbus CRC-16, one byte, LSB first.
  function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) c = (c >> 1) ^ CRC_POLY;
      else      c = c >> 1;
    end
    return c;
  endfunction

  function automatic logic address_known(input logic [15:0] a);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < ADDR_TABLE_USED; i++) begin
      if (KNOWN_ADDR[i] == a) hit = 1'b1;
    end
    return hit;
  endfunction

endpackage

// File: sv/rrf_front.sv
// Front end: byte acceptance, frame parsing, CRC and event classification.
`timescale 1ns / 1ps
module rrf_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_rx_byte,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic                 cfg_index,
  input  logic [15:0]          cfg_data,
  input  rrf_pkg::rrf_q_status_t q_status,
  output logic                 push,
  output rrf_pkg::rrf_event_t  push_event
);
  import rrf_pkg::*;

  typedef enum logic [2:0] {
    PH_ID, PH_FUNC, PH_ADDR, PH_COUNT, PH_CRC, PH_BCOUNT, PH_DATA
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  func_r, func_nxt;
  logic [15:0] addr_r, addr_nxt;
  logic [15:0] wcount_r, wcount_nxt;
  logic [7:0]  bcount_r, bcount_nxt;
  logic [7:0]  seen_r, seen_nxt;
  logic [7:0]  own_id_r;
  logic [15:0] max_wc_r;

  logic        accept;
  logic [15:0] crc_step;
  logic [7:0]  seen_inc;
  logic [1:0]  ev_kind;
  logic [2:0]  ev_cause;
  logic [7:0]  ev_byte;
  logic [7:0]  ev_idx;
  logic        ev_fire;

  assign in_stall  = q_status.full;
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !in_stall;
  assign crc_step  = crc_update((phase_r == PH_ID) ? CRC_INIT : crc_r, in_rx_byte);
  assign seen_inc  = seen_r + 8'd1;

  always_comb begin
    phase_nxt  = phase_r;
    crc_nxt    = crc_r;
    func_nxt   = func_r;
    addr_nxt   = addr_r;
    wcount_nxt = wcount_r;
    bcount_nxt = bcount_r;
    seen_nxt   = seen_r;
    ev_fire    = 1'b0;
    ev_kind    = EV_DATA;
    ev_cause   = RC_NONE;
    ev_byte    = 8'h00;
    ev_idx     = 8'h00;
    if (accept) begin
      crc_nxt = crc_step;
      case (phase_r)
        PH_FUNC: begin
          func_nxt = in_rx_byte;
          if (in_rx_byte != FC_READ && in_rx_byte != FC_WRITE) begin
            phase_nxt = PH_ID;
            ev_fire   = 1'b1;
            ev_kind   = EV_REJECT;
            ev_cause  = RC_BAD_FUNC;
          end else begin
            phase_nxt = PH_ADDR;
            seen_nxt  = 8'd0;
          end
        end
        PH_ADDR: begin
          addr_nxt = {addr_r[7:0], in_rx_byte};
          if (seen_r == 8'd0) begin
            seen_nxt = 8'd1;
          end else if (!address_known(addr_nxt)) begin
            phase_nxt = PH_ID;
            ev_fire   = 1'b1;
            ev_kind   = EV_REJECT;
            ev_cause  = RC_BAD_ADDR;
          end else begin
            phase_nxt = PH_COUNT;
            seen_nxt  = 8'd0;
          end
        end
        PH_COUNT: begin
          wcount_nxt = {wcount_r[7:0], in_rx_byte};
          if (seen_r == 8'd0) begin
            seen_nxt = 8'd1;
          end else if (wcount_nxt > max_wc_r) begin
            phase_nxt = PH_ID;
            ev_fire   = 1'b1;
            ev_kind   = EV_REJECT;
            ev_cause  = RC_COUNT;
          end else begin
            phase_nxt = (func_r == FC_WRITE) ? PH_BCOUNT : PH_CRC;
            seen_nxt  = 8'd0;
          end
        end
        PH_BCOUNT: begin
          bcount_nxt = in_rx_byte;
          seen_nxt   = 8'd0;
          phase_nxt  = (in_rx_byte == 8'd0) ? PH_CRC : PH_DATA;
        end
        PH_DATA: begin
          ev_fire = 1'b1;
          ev_kind = EV_DATA;
          ev_byte = in_rx_byte;
          ev_idx  = seen_r;
          if (seen_inc == bcount_r) begin
            phase_nxt = PH_CRC;
            seen_nxt  = 8'd0;
          end else begin
            seen_nxt  = seen_inc;
          end
        end
        PH_CRC: begin
          if (seen_r == 8'd0) begin
            seen_nxt = 8'd1;
          end else begin
            phase_nxt = PH_ID;
            ev_fire   = 1'b1;
            if (crc_step != 16'h0000) begin
              ev_kind  = EV_REJECT;
              ev_cause = RC_CRC;
            end else begin
              ev_kind  = (func_r == FC_WRITE) ? EV_WRITE_OK : EV_READ_OK;
            end
          end
        end
        default: begin
          // waiting for slave id: every byte starts a fresh frame
          func_nxt   = 8'h00;
          addr_nxt   = 16'h0000;
          wcount_nxt = 16'h0000;
          bcount_nxt = 8'h00;
          seen_nxt   = 8'd0;
          if (in_rx_byte != own_id_r) begin
            crc_nxt   = CRC_INIT;
            phase_nxt = PH_ID;
            ev_fire   = 1'b1;
            ev_kind   = EV_REJECT;
            ev_cause  = RC_OTHER_ID;
          end else begin
            phase_nxt = PH_FUNC;
          end
        end
      endcase
    end
  end

  assign push                        = ev_fire;
  assign push_event.event_kind       = ev_kind;
  assign push_event.data_byte        = ev_byte;
  assign push_event.data_index       = ev_idx;
  assign push_event.function_code    = func_nxt;
  assign push_event.register_address = addr_nxt;
  assign push_event.word_count       = wcount_nxt;
  assign push_event.byte_count       = bcount_nxt;
  assign push_event.reject_cause     = ev_cause;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_ID;
      crc_r    <= CRC_INIT;
      func_r   <= 8'h00;
      addr_r   <= 16'h0000;
      wcount_r <= 16'h0000;
      bcount_r <= 8'h00;
      seen_r   <= 8'd0;
      own_id_r <= OWN_ID_RESET;
      max_wc_r <= MAX_WC_RESET;
    end else begin
      phase_r  <= phase_nxt;
      crc_r    <= crc_nxt;
      func_r   <= func_nxt;
      addr_r   <= addr_nxt;
      wcount_r <= wcount_nxt;
      bcount_r <= bcount_nxt;
      seen_r   <= seen_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_OWN_SLAVE_ID)   own_id_r <= cfg_data[7:0];
        if (cfg_index == REG_MAX_WORD_COUNT) max_wc_r <= cfg_data;
      end
    end
  end

endmodule

// File: sv/rrf_queue.sv
// Two-entry event queue between the parser and the output stage.
`timescale 1ns / 1ps
module rrf_queue (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  rrf_pkg::rrf_event_t    push_event,
  input  logic                   pop,
  output rrf_pkg::rrf_event_t    head_event,
  output rrf_pkg::rrf_q_status_t q_status
);
  import rrf_pkg::*;

  rrf_event_t entry_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_push;
  logic       do_pop;

  assign q_status.full  = (count_r == 2'd2);
  assign q_status.empty = (count_r == 2'd0);
  assign do_push        = push && !q_status.full;
  assign do_pop         = pop && !q_status.empty;
  assign head_event     = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) entry_r[wr_ptr_r] <= push_event;
  end

endmodule

// File: sv/rrf_back.sv
// Back end: output register that presents queued events on the result channel.
`timescale 1ns / 1ps
module rrf_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  rrf_pkg::rrf_q_status_t q_status,
  input  rrf_pkg::rrf_event_t    head_event,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [1:0]             out_event_kind,
  output logic [7:0]             out_data_byte,
  output logic [7:0]             out_data_index,
  output logic [7:0]             out_function_code,
  output logic [15:0]            out_register_address,
  output logic [15:0]            out_word_count,
  output logic [7:0]             out_byte_count,
  output logic [2:0]             out_reject_cause
);
  import rrf_pkg::*;

  logic       out_valid_r, out_valid_nxt;
  rrf_event_t out_event_r;

  // refill the output register whenever it is empty or being taken
  assign pop = !q_status.empty && (!out_valid_r || !out_stall);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop)               out_valid_nxt = 1'b1;
    else if (!out_stall)   out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= out_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (pop) out_event_r <= head_event;
  end

  assign out_valid            = out_valid_r;
  assign out_event_kind       = out_event_r.event_kind;
  assign out_data_byte        = out_event_r.data_byte;
  assign out_data_index       = out_event_r.data_index;
  assign out_function_code    = out_event_r.function_code;
  assign out_register_address = out_event_r.register_address;
  assign out_word_count       = out_event_r.word_count;
  assign out_byte_count       = out_event_r.byte_count;
  assign out_reject_cause     = out_event_r.reject_cause;

endmodule

// File: sv/rtu_request_frame_receiver.sv
// Top level of the RTU request frame receiver.
`timescale 1ns / 1ps
// Usage:
// - Input channel: one received serial byte per item on in_rx_byte, taken at
//   an edge with in_valid high and in_stall low; one per cycle while not stalled.
// - Result channel: at most one event per byte (write data byte, read frame
//   good, write frame good, or reject with cause), valid/stall handshake.
// - Config channel: cfg_index 0 writes own slave id (cfg_data[7:0]), index 1
//   writes the max word count. cfg_ready is always high; write only when idle.
// - Path: an event is written into the queue at the edge that takes its byte,
//   then moves on to the output register, which drives out_valid.
//   Throughput: one item per cycle while in_stall is low; the parser does the
//   CRC byte update and the address compare combinationally.
// - A two-entry queue sits between parser and output register. When the
//   receiver stalls, the queue fills and in_stall rises once it is full; the
//   pending output holds steady.
// - Reset: parser waits for a slave id, CRC back to 0xFFFF, own id 0, max
//   word count 100, queue and output register empty.
module rtu_request_frame_receiver (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_event_kind,
  output logic [7:0]  out_data_byte,
  output logic [7:0]  out_data_index,
  output logic [7:0]  out_function_code,
  output logic [15:0] out_register_address,
  output logic [15:0] out_word_count,
  output logic [7:0]  out_byte_count,
  output logic [2:0]  out_reject_cause,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);
  import rrf_pkg::*;

  rrf_q_status_t q_status;
  rrf_event_t    push_event;
  rrf_event_t    head_event;
  logic          push;
  logic          pop;

  rrf_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .q_status   (q_status),
    .push       (push),
    .push_event (push_event)
  );

  rrf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_event (push_event),
    .pop        (pop),
    .head_event (head_event),
    .q_status   (q_status)
  );

  rrf_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .q_status             (q_status),
    .head_event           (head_event),
    .pop                  (pop),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_event_kind       (out_event_kind),
    .out_data_byte        (out_data_byte),
    .out_data_index       (out_data_index),
    .out_function_code    (out_function_code),
    .out_register_address (out_register_address),
    .out_word_count       (out_word_count),
    .out_byte_count       (out_byte_count),
    .out_reject_cause     (out_reject_cause)
  );

endmodule

// File: tb/rrf_frame_checker.sv
// Checker for the RTU request receiver: tracks the byte stream, predicts events, compares.
`timescale 1ns / 1ps
module rrf_frame_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  out_event_kind,
  input  logic [7:0]  out_data_byte,
  input  logic [7:0]  out_data_index,
  input  logic [7:0]  out_function_code,
  input  logic [15:0] out_register_address,
  input  logic [15:0] out_word_count,
  input  logic [7:0]  out_byte_count,
  input  logic [2:0]  out_reject_cause,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  output int          fail_count,
  output int          pending,
  output int          checked
);
  import rrf_pkg::*;

  localparam int MAX_SHOWN = 10;

  typedef enum logic [2:0] {
    ST_WAIT_ID, ST_FUNC, ST_ADDR, ST_COUNT, ST_CRC, ST_BCOUNT, ST_DATA
  } parse_st_t;

  parse_st_t   st;
  logic [15:0] crc;
  logic [7:0]  held_fn;
  logic [15:0] held_addr;
  logic [15:0] held_wc;
  logic [7:0]  held_bc;
  logic [7:0]  seen;
  logic [7:0]  own_id;
  logic [15:0] max_wc;

  rrf_event_t  expected_events [$];
  rrf_event_t  got;
  rrf_event_t  want;

  // Bitwise form of the reflected CRC-16 (0xA001).
  function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    logic        fb;
    r = c;
    for (int i = 0; i < 8; i++) begin
      fb = r[0] ^ b[i];
      r  = r >> 1;
      if (fb) r = r ^ 16'hA001;
    end
    return r;
  endfunction

  function automatic logic addr_listed(input logic [15:0] a);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < ADDR_TABLE_ENTRIES && i < $size(KNOWN_ADDR); i++)
      if (KNOWN_ADDR[i] == a) hit = 1'b1;
    return hit;
  endfunction

  function automatic rrf_event_t held_event(input logic [1:0] kind, input logic [7:0] dbyte,
                                            input logic [7:0] didx, input logic [2:0] cause);
    rrf_event_t e;
    e.event_kind       = kind;
    e.data_byte        = dbyte;
    e.data_index       = didx;
    e.function_code    = held_fn;
    e.register_address = held_addr;
    e.word_count       = held_wc;
    e.byte_count       = held_bc;
    e.reject_cause     = cause;
    return e;
  endfunction

  task automatic reject_frame(input logic [2:0] cause);
    st = ST_WAIT_ID;
    expected_events.push_back(held_event(EV_REJECT, 8'h00, 8'h00, cause));
  endtask

  task automatic advance_parser(input logic [7:0] b);
    logic [7:0] idx;
    case (st)
      ST_FUNC: begin
        crc = crc_step(crc, b);
        held_fn = b;
        if (b != FC_READ && b != FC_WRITE) begin
          reject_frame(RC_BAD_FUNC);
        end else begin
          st = ST_ADDR;
          seen = 8'd0;
        end
      end
      ST_ADDR: begin
        crc = crc_step(crc, b);
        held_addr = {held_addr[7:0], b};
        if (seen == 8'd0) begin
          seen = 8'd1;
        end else if (!addr_listed(held_addr)) begin
          reject_frame(RC_BAD_ADDR);
        end else begin
          st = ST_COUNT;
          seen = 8'd0;
        end
      end
      ST_COUNT: begin
        crc = crc_step(crc, b);
        held_wc = {held_wc[7:0], b};
        if (seen == 8'd0) begin
          seen = 8'd1;
        end else if (held_wc > max_wc) begin
          reject_frame(RC_COUNT);
        end else begin
          st = (held_fn == FC_WRITE) ? ST_BCOUNT : ST_CRC;
          seen = 8'd0;
        end
      end
      ST_BCOUNT: begin
        crc = crc_step(crc, b);
        held_bc = b;
        seen = 8'd0;
        st = (b == 8'd0) ? ST_CRC : ST_DATA;
      end
      ST_DATA: begin
        idx = seen;
        crc = crc_step(crc, b);
        seen = seen + 8'd1;
        if (seen == held_bc) begin
          st = ST_CRC;
          seen = 8'd0;
        end
        expected_events.push_back(held_event(EV_DATA, b, idx, RC_NONE));
      end
      ST_CRC: begin
        crc = crc_step(crc, b);
        if (seen == 8'd0) begin
          seen = 8'd1;
        end else if (crc != 16'h0000) begin
          reject_frame(RC_CRC);
        end else begin
          st = ST_WAIT_ID;
          expected_events.push_back(held_event((held_fn == FC_WRITE) ? EV_WRITE_OK : EV_READ_OK,
                                               8'h00, 8'h00, RC_NONE));
        end
      end
      default: begin
        held_fn   = 8'h00;
        held_addr = 16'h0000;
        held_wc   = 16'h0000;
        held_bc   = 8'h00;
        seen      = 8'd0;
        crc       = CRC_INIT;
        if (b != own_id) begin
          // other slave: reject with everything else zero, keep hunting for an id
          st = ST_WAIT_ID;
          expected_events.push_back(held_event(EV_REJECT, 8'h00, 8'h00, RC_OTHER_ID));
        end else begin
          crc = crc_step(crc, b);
          st = ST_FUNC;
        end
      end
    endcase
  endtask

  task automatic show_event(input string tag, input rrf_event_t e);
    $display("    %s kind=%0d byte=%02h idx=%0d fc=%02h addr=%04h wc=%0d bc=%0d cause=%0d",
             tag, e.event_kind, e.data_byte, e.data_index, e.function_code,
             e.register_address, e.word_count, e.byte_count, e.reject_cause);
  endtask

  task automatic log_failure(input string what, input bit with_want);
    fail_count++;
    if (fail_count <= MAX_SHOWN) begin
      $display("[%0t] event check: %s", $time, what);
      if (with_want) show_event("expected", want);
      show_event("actual  ", got);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      st        = ST_WAIT_ID;
      crc       = CRC_INIT;
      held_fn   = 8'h00;
      held_addr = 16'h0000;
      held_wc   = 16'h0000;
      held_bc   = 8'h00;
      seen      = 8'd0;
      own_id    = OWN_ID_RESET;
      max_wc    = MAX_WC_RESET;
      expected_events.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_OWN_SLAVE_ID) own_id = cfg_data[7:0];
        else max_wc = cfg_data;
      end
      if (in_valid && !in_stall) advance_parser(in_rx_byte);
      if (out_valid && !out_stall) begin
        got = {out_event_kind, out_data_byte, out_data_index, out_function_code,
               out_register_address, out_word_count, out_byte_count, out_reject_cause};
        checked++;
        if (expected_events.size() == 0) begin
          log_failure("event with nothing expected", 1'b0);
        end else begin
          want = expected_events.pop_front();
          if (got.event_kind !== want.event_kind || got.data_byte !== want.data_byte ||
              got.data_index !== want.data_index ||
              got.function_code !== want.function_code ||
              got.register_address !== want.register_address ||
              got.word_count !== want.word_count || got.byte_count !== want.byte_count ||
              got.reject_cause !== want.reject_cause)
            log_failure("field mismatch", 1'b1);
        end
      end
    end
    pending = expected_events.size();
  end

endmodule

// File: tb/tb_rtu_request_frame_receiver.sv
// Testbench top for the RTU request receiver: clock, reset, byte stimulus, verdict.
`timescale 1ns / 1ps
module tb_rtu_request_frame_receiver;
  import rrf_pkg::*;

  localparam int CYCLE_LIMIT   = 500000;
  localparam int SETTLE_CYCLES = 6;
  localparam int TAIL_CYCLES   = 10;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_event_kind;
  logic [7:0]  out_data_byte;
  logic [7:0]  out_data_index;
  logic [7:0]  out_function_code;
  logic [15:0] out_register_address;
  logic [15:0] out_word_count;
  logic [7:0]  out_byte_count;
  logic [2:0]  out_reject_cause;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [15:0] cfg_data = 16'h0000;

  int fail_count;
  int pending;
  int checked;

  int          cycles = 0;
  int          bytes_sent = 0;
  int          frames_sent = 0;
  int          settings_used = 1;
  int          stall_left = 0;
  bit          idle_on = 1'b0;
  logic [7:0]  cur_id = OWN_ID_RESET;
  logic [15:0] cur_max = MAX_WC_RESET;
  logic [7:0]  frame [$];

  rtu_request_frame_receiver uut (.*);

  rrf_frame_checker u_checker (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_rtu_request_frame_receiver: FAIL");
      $finish;
    end
  end

  // receiver back-pressure in random bursts
  always @(negedge clk) begin
    if (!idle_on) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 11) == 0) begin
      stall_left = $urandom_range(1, 15) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Entered and left just after a falling edge; valid stays up for a following item.
  task automatic send_byte(input logic [7:0] b);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(input logic idx, input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [15:0] frame_crc();
    logic [15:0] c;
    c = CRC_INIT;
    foreach (frame[i]) begin
      c = c ^ {8'h00, frame[i]};
      for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // keep > 0 cuts the frame after that many bytes (at the rejecting field)
  task automatic send_request(input logic [7:0] id, input logic [7:0] fn,
                              input logic [15:0] addr, input logic [15:0] wc,
                              input logic [7:0] bc, input bit corrupt, input int keep);
    logic [15:0] c;
    frame.delete();
    frame.push_back(id);
    frame.push_back(fn);
    frame.push_back(addr[15:8]);
    frame.push_back(addr[7:0]);
    frame.push_back(wc[15:8]);
    frame.push_back(wc[7:0]);
    if (fn == FC_WRITE) begin
      frame.push_back(bc);
      for (int i = 0; i < bc; i++) frame.push_back(8'($urandom_range(0, 255)));
    end
    c = frame_crc();
    if (corrupt) c = c ^ (16'h0001 << $urandom_range(0, 15));
    frame.push_back(c[7:0]);
    frame.push_back(c[15:8]);
    if (keep > 0)
      while (frame.size() > keep) frame.delete(frame.size() - 1);
    foreach (frame[i]) send_byte(frame[i]);
    frames_sent++;
  endtask

  task automatic random_frame();
    int          pick;
    int          keep;
    int          n;
    logic [7:0]  id;
    logic [7:0]  fn;
    logic [7:0]  bc;
    logic [15:0] addr;
    logic [15:0] wc;
    bit          corrupt;
    pick    = $urandom_range(0, 99);
    id      = cur_id;
    fn      = $urandom_range(0, 1) ? FC_WRITE : FC_READ;
    addr    = KNOWN_ADDR[$urandom_range(0, ADDR_TABLE_USED - 1)];
    wc      = ($urandom_range(0, 7) == 0) ? cur_max : 16'($urandom_range(0, cur_max));
    bc      = ($urandom_range(0, 15) == 0) ? 8'($urandom_range(13, 60))
                                           : 8'($urandom_range(0, 12));
    corrupt = 1'b0;
    keep    = 0;
    if (pick < 70) begin
      corrupt = ($urandom_range(0, 9) == 0);
    end else if (pick < 76) begin
      id = cur_id ^ 8'($urandom_range(1, 255));
      keep = 1;
    end else if (pick < 82) begin
      fn = 8'($urandom_range(0, 255));
      keep = 2;
    end else if (pick < 88) begin
      // fully random or a near miss next to a listed address
      addr = $urandom_range(0, 1) ? 16'($urandom_range(0, 65535)) : addr + 16'h0001;
      keep = 4;
    end else if (pick < 93) begin
      if (cur_max != 16'hFFFF) wc = 16'($urandom_range(cur_max + 1, 65535));
      keep = 6;
    end else begin
      // line noise between frames
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++) send_byte(8'($urandom_range(0, 255)));
      return;
    end
    send_request(id, fn, addr, wc, bc, corrupt, keep);
  endtask

  task automatic run_setting(input logic [7:0] id, input logic [15:0] limit_wc,
                             input int budget, input bit noisy, input bit long_write);
    int start;
    wait_idle();
    cfg_write(REG_OWN_SLAVE_ID, {8'h00, id});
    cfg_write(REG_MAX_WORD_COUNT, limit_wc);
    cur_id  = id;
    cur_max = limit_wc;
    idle_on = noisy;
    settings_used++;
    start = bytes_sent;
    if (long_write) send_request(cur_id, FC_WRITE, KNOWN_ADDR[0], 16'd0, 8'd255, 1'b0, 0);
    while (bytes_sent - start < budget) begin
      random_frame();
      if ($urandom_range(0, 39) == 0) wait_idle();
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed frames under reset settings (own id 0, word count limit 100)
    send_byte(8'hFF);
    send_request(8'h00, 8'hFF, 16'h0000, 16'h0000, 8'h00, 1'b0, 2);
    send_request(8'h00, FC_READ, 16'hFFFF, 16'h0000, 8'h00, 1'b0, 4);
    send_request(8'h00, FC_WRITE, 16'h1100, 16'd101, 8'h00, 1'b0, 6);
    send_request(8'h00, FC_WRITE, 16'h8000, 16'd100, 8'h00, 1'b0, 0);
    send_request(8'h00, FC_READ, 16'h1100, 16'h0000, 8'h00, 1'b0, 0);

    run_setting(8'hFF, 16'h0000, 400, 1'b1, 1'b0);
    run_setting(8'($urandom_range(0, 255)), 16'hFFFF, 600, 1'b1, 1'b1);
    run_setting(8'($urandom_range(0, 255)), 16'($urandom_range(1, 2000)), 400, 1'b1, 1'b0);
    run_setting(8'h00, 16'($urandom_range(0, 300)), 350, 1'b0, 1'b0);

    wait_idle();
    repeat (TAIL_CYCLES) @(negedge clk);
    $display("Sent %0d bytes in %0d requests plus noise, over %0d register settings.",
             bytes_sent, frames_sent, settings_used);
    $display("Checked %0d events against prediction, %0d failures.", checked, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_rtu_request_frame_receiver: PASS");
    end else begin
      $display("tb_rtu_request_frame_receiver: FAIL");
    end
    $finish;
  end

endmodule

// File: rtu_request_frame_receiver.f
sv/rrf_pkg.sv
sv/rrf_front.sv
sv/rrf_queue.sv
sv/rrf_back.sv
sv/rtu_request_frame_receiver.sv
tb/rrf_frame_checker.sv
tb/tb_rtu_request_frame_receiver.sv
